// ----- rtl/pqrho_pkg.sv -----
package pqrho_pkg;

	// Widths of the data path and of the result fields
	localparam int N_W = 64;
	localparam int F_W = 32;
	localparam int CB_W = 16;
	localparam int BYTES_W = 3;
	localparam int STATUS_W = 2;

	// Search budget
	localparam int ROUND_SHIFT = 18;
	localparam int MIN_ROUNDS = 3;
	localparam int MIN_STEPS = 10;
	// Every round takes at least one step, so the round index stays below this
	localparam int R_LIMIT = (MIN_ROUNDS > MIN_STEPS) ? MIN_ROUNDS : MIN_STEPS;
	localparam int R_W = $clog2(R_LIMIT);
	localparam int J_W = ROUND_SHIFT + R_LIMIT - 1;
	localparam int STEP_W = $clog2(MIN_STEPS + 1);
	localparam int K_W = $clog2(N_W);
	localparam int CNT_W = $clog2(N_W);

	// Step limit mask of round 0: 2^ROUND_SHIFT - 1
	localparam logic [J_W-1:0] MASK0 = {J_W{1'b1}} >> (J_W - ROUND_SHIFT);
	// Added to the polynomial constant on odd rounds
	localparam logic [CB_W:0] ODD_ROUND_ADD = (CB_W + 1)'(16);

	// Configuration
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONST_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SEED = 1'b1;
	localparam logic [CB_W-1:0] CONST_BASE_RST = CB_W'(17);
	localparam logic [N_W-1:0] START_SEED_RST = '0;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

	typedef enum logic [15:0] {
		S_IDLE   = 16'b0000_0000_0000_0001,
		S_NM1    = 16'b0000_0000_0000_0010,
		S_RINIT  = 16'b0000_0000_0000_0100,
		S_DIV    = 16'b0000_0000_0000_1000,
		S_DEND   = 16'b0000_0000_0001_0000,
		S_XSET   = 16'b0000_0000_0010_0000,
		S_MSTART = 16'b0000_0000_0100_0000,
		S_MBIT   = 16'b0000_0000_1000_0000,
		S_MRED   = 16'b0000_0001_0000_0000,
		S_MDBL   = 16'b0000_0010_0000_0000,
		S_ZSUB   = 16'b0000_0100_0000_0000,
		S_ZADD   = 16'b0000_1000_0000_0000,
		S_GCD    = 16'b0001_0000_0000_0000,
		S_GSH    = 16'b0010_0000_0000_0000,
		S_REND   = 16'b0100_0000_0000_0000,
		S_FIN    = 16'b1000_0000_0000_0000
	} state_t;

	// What a divider run is for
	typedef enum logic [1:0] {
		DK_SEED  = 2'd0,
		DK_CONST = 2'd1,
		DK_QUOT  = 2'd2
	} div_kind_t;

	// Minimal big-endian byte count, 1..4
	function automatic logic [BYTES_W-1:0] byte_len(input logic [F_W-1:0] v);
		logic [BYTES_W-1:0] len;
		if (v[31:8] == '0) begin
			len = 3'd1;
		end else if (v[31:16] == '0) begin
			len = 3'd2;
		end else if (v[31:24] == '0) begin
			len = 3'd3;
		end else begin
			len = 3'd4;
		end
		return len;
	endfunction

endpackage

// ----- rtl/pq_factorization_pollard_rho_core.sv -----
// Work: one rho step is a shift-and-add modular multiply followed by a binary gcd; each
//   round adds two 64-bit divisions (seed mod n-1, constant mod n), a found factor one
//   more (n / g). Rejected inputs (below 4) answer in the cycle after the request.
// Throughput: one request at a time; busy stays high until the result strobe, and a
//   rejected input never raises it. The single 66-bit add/subtract unit serves all arithmetic.
// Reset: arst_n clears the sequencer and loads const_base = 17, start_seed = 0.
module pq_factorization_pollard_rho_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request
	input  logic                                  start,
	output logic                                  busy,
	input  logic [pqrho_pkg::N_W-1:0]             composite,
	// result, one cycle per strobe
	output logic                                  done,
	output logic [pqrho_pkg::F_W-1:0]             small_factor,
	output logic [pqrho_pkg::F_W-1:0]             large_factor,
	output logic [pqrho_pkg::BYTES_W-1:0]         small_bytes,
	output logic [pqrho_pkg::BYTES_W-1:0]         large_bytes,
	output logic [pqrho_pkg::STATUS_W-1:0]        status,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [pqrho_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pqrho_pkg::N_W-1:0]             cfg_wdata
);

	localparam int N_W = pqrho_pkg::N_W;

	pqrho_pkg::state_t state_q;
	pqrho_pkg::div_kind_t kind_q;

	// Configuration
	logic [pqrho_pkg::CB_W-1:0] const_base_q;
	logic [N_W-1:0] start_seed_q;

	// Search control
	logic [pqrho_pkg::R_W-1:0] r_q;
	logic [pqrho_pkg::STEP_W-1:0] steps_q;
	logic [pqrho_pkg::J_W-1:0] mask_q;
	logic [pqrho_pkg::J_W-1:0] j_q;
	logic [pqrho_pkg::K_W-1:0] k_q;
	logic [pqrho_pkg::CNT_W-1:0] cnt_q;

	// Operands and walk state
	logic [N_W-1:0] n_q;
	logic [N_W-1:0] nm1_q;
	logic [N_W-1:0] x_q;
	logic [N_W-1:0] y_q;
	logic [N_W-1:0] c_q;
	logic [N_W-1:0] g_q;
	logic [N_W-1:0] div_d_q;
	// wa: multiplicand a / divider remainder / gcd u / difference z
	// wb: multiplier bits b / divider quotient / gcd v
	logic [N_W-1:0] wa_q;
	logic [N_W-1:0] wb_q;
	logic [N_W:0] acc_q;

	// Result registers
	logic done_q;
	logic [pqrho_pkg::F_W-1:0] small_q;
	logic [pqrho_pkg::F_W-1:0] large_q;
	logic [pqrho_pkg::BYTES_W-1:0] small_bytes_q;
	logic [pqrho_pkg::BYTES_W-1:0] large_bytes_q;
	logic [pqrho_pkg::STATUS_W-1:0] status_q;

	// Shared add/subtract unit: 65-bit operands, 66-bit result, bit 65 is the borrow
	logic [N_W:0] alu_a;
	logic [N_W:0] alu_b;
	logic alu_sub;
	logic [N_W+1:0] alu_b_ext;
	logic [N_W+1:0] alu_res;
	logic alu_neg;

	// Misc decode
	logic [pqrho_pkg::CB_W:0] cst_dividend;
	logic j_pow2;
	logic [N_W-1:0] fin_small;
	logic [N_W-1:0] fin_large;

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			pqrho_pkg::S_NM1: begin
				alu_a = {1'b0, n_q};
				alu_b = (N_W + 1)'(1);
				alu_sub = 1'b1;
			end
			pqrho_pkg::S_RINIT: begin
				alu_a = {1'b0, start_seed_q};
				alu_b = (N_W + 1)'(r_q);
			end
			pqrho_pkg::S_DIV: begin
				// restoring division: shift next dividend bit into remainder, trial subtract
				alu_a = {wa_q, wb_q[N_W-1]};
				alu_b = {1'b0, div_d_q};
				alu_sub = 1'b1;
			end
			pqrho_pkg::S_XSET: begin
				alu_a = {1'b0, wa_q};
				alu_b = (N_W + 1)'(1);
			end
			pqrho_pkg::S_MBIT: begin
				alu_a = acc_q;
				alu_b = {1'b0, wa_q};
			end
			pqrho_pkg::S_MRED: begin
				alu_a = acc_q;
				alu_b = {1'b0, n_q};
				alu_sub = 1'b1;
			end
			pqrho_pkg::S_MDBL: begin
				alu_a = {wa_q, 1'b0};
				alu_b = {1'b0, n_q};
				alu_sub = 1'b1;
			end
			pqrho_pkg::S_ZSUB: begin
				alu_a = {1'b0, x_q};
				alu_b = {1'b0, y_q};
				alu_sub = 1'b1;
			end
			pqrho_pkg::S_ZADD: begin
				alu_a = {1'b0, wa_q};
				alu_b = {1'b0, n_q};
			end
			pqrho_pkg::S_GCD: begin
				alu_a = {1'b0, wa_q};
				alu_b = {1'b0, wb_q};
				alu_sub = 1'b1;
			end
			pqrho_pkg::S_FIN: begin
				alu_a = {1'b0, g_q};
				alu_b = {1'b0, wb_q};
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_b_ext = {1'b0, alu_b} ^ {(N_W + 2){alu_sub}};
	assign alu_res = {1'b0, alu_a} + alu_b_ext + (N_W + 2)'(alu_sub);
	assign alu_neg = alu_res[N_W+1];

	// Polynomial constant before reduction: const_base, plus 16 on odd rounds
	assign cst_dividend = {1'b0, const_base_q} + (r_q[0] ? pqrho_pkg::ODD_ROUND_ADD : '0);
	// y is refreshed after steps whose index is a power of two
	assign j_pow2 = (j_q & (j_q - pqrho_pkg::J_W'(1))) == '0;
	// Order the factor pair; on a tie either order gives the same answer
	assign fin_small = alu_neg ? g_q : wb_q;
	assign fin_large = alu_neg ? wb_q : g_q;

	// Configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			const_base_q <= pqrho_pkg::CONST_BASE_RST;
			start_seed_q <= pqrho_pkg::START_SEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pqrho_pkg::CFG_CONST_BASE: const_base_q <= cfg_wdata[pqrho_pkg::CB_W-1:0];
				pqrho_pkg::CFG_START_SEED: start_seed_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer and data path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pqrho_pkg::S_IDLE;
			kind_q <= pqrho_pkg::DK_SEED;
			done_q <= 1'b0;
			r_q <= '0;
			steps_q <= '0;
			mask_q <= pqrho_pkg::MASK0;
			j_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			status_q <= '0;
			small_q <= '0;
			large_q <= '0;
			small_bytes_q <= '0;
			large_bytes_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				pqrho_pkg::S_IDLE: begin
					if (start) begin
						n_q <= composite;
						if (composite[N_W-1:2] == '0) begin
							// below 4: nothing to factor
							status_q <= pqrho_pkg::ST_REJECT;
							small_q <= '0;
							large_q <= '0;
							small_bytes_q <= '0;
							large_bytes_q <= '0;
							done_q <= 1'b1;
						end else begin
							state_q <= pqrho_pkg::S_NM1;
						end
					end
				end
				pqrho_pkg::S_NM1: begin
					nm1_q <= alu_res[N_W-1:0];
					r_q <= '0;
					steps_q <= '0;
					mask_q <= pqrho_pkg::MASK0;
					state_q <= pqrho_pkg::S_RINIT;
				end
				pqrho_pkg::S_RINIT: begin
					// start value: (seed + r) mod (n-1), then +1
					wb_q <= alu_res[N_W-1:0];
					wa_q <= '0;
					div_d_q <= nm1_q;
					cnt_q <= '1;
					kind_q <= pqrho_pkg::DK_SEED;
					j_q <= pqrho_pkg::J_W'(1);
					state_q <= pqrho_pkg::S_DIV;
				end
				pqrho_pkg::S_DIV: begin
					if (alu_neg) begin
						wa_q <= {wa_q[N_W-2:0], wb_q[N_W-1]};
					end else begin
						wa_q <= alu_res[N_W-1:0];
					end
					wb_q <= {wb_q[N_W-2:0], ~alu_neg};
					cnt_q <= cnt_q - pqrho_pkg::CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= pqrho_pkg::S_DEND;
					end
				end
				pqrho_pkg::S_DEND: begin
					unique case (kind_q)
						pqrho_pkg::DK_SEED: state_q <= pqrho_pkg::S_XSET;
						pqrho_pkg::DK_CONST: begin
							c_q <= wa_q;
							state_q <= pqrho_pkg::S_MSTART;
						end
						pqrho_pkg::DK_QUOT: state_q <= pqrho_pkg::S_FIN;
						default: state_q <= pqrho_pkg::S_IDLE;
					endcase
				end
				pqrho_pkg::S_XSET: begin
					x_q <= alu_res[N_W-1:0];
					y_q <= alu_res[N_W-1:0];
					// next: constant mod n
					wb_q <= N_W'(cst_dividend);
					wa_q <= '0;
					div_d_q <= n_q;
					cnt_q <= '1;
					kind_q <= pqrho_pkg::DK_CONST;
					state_q <= pqrho_pkg::S_DIV;
				end
				pqrho_pkg::S_MSTART: begin
					if (steps_q < pqrho_pkg::STEP_W'(pqrho_pkg::MIN_STEPS)) begin
						steps_q <= steps_q + pqrho_pkg::STEP_W'(1);
					end
					wa_q <= x_q;
					wb_q <= x_q;
					acc_q <= {1'b0, c_q};
					state_q <= pqrho_pkg::S_MBIT;
				end
				pqrho_pkg::S_MBIT: begin
					// shift-and-add x*x + c mod n, LSB first
					if (wb_q == '0) begin
						x_q <= acc_q[N_W-1:0];
						state_q <= pqrho_pkg::S_ZSUB;
					end else if (wb_q[0]) begin
						acc_q <= alu_res[N_W:0];
						state_q <= pqrho_pkg::S_MRED;
					end else begin
						state_q <= pqrho_pkg::S_MDBL;
					end
				end
				pqrho_pkg::S_MRED: begin
					if (!alu_neg) begin
						acc_q <= alu_res[N_W:0];
					end
					state_q <= pqrho_pkg::S_MDBL;
				end
				pqrho_pkg::S_MDBL: begin
					if (alu_neg) begin
						wa_q <= {wa_q[N_W-2:0], 1'b0};
					end else begin
						wa_q <= alu_res[N_W-1:0];
					end
					wb_q <= wb_q >> 1;
					state_q <= pqrho_pkg::S_MBIT;
				end
				pqrho_pkg::S_ZSUB: begin
					// |x - y| taken as x - y, or n - y + x on wrap
					wa_q <= alu_res[N_W-1:0];
					wb_q <= n_q;
					k_q <= '0;
					state_q <= alu_neg ? pqrho_pkg::S_ZADD : pqrho_pkg::S_GCD;
				end
				pqrho_pkg::S_ZADD: begin
					wa_q <= alu_res[N_W-1:0];
					state_q <= pqrho_pkg::S_GCD;
				end
				pqrho_pkg::S_GCD: begin
					// binary gcd, one shift, subtract or swap per cycle
					if (wa_q == '0 || wb_q == '0) begin
						g_q <= wa_q | wb_q;
						state_q <= pqrho_pkg::S_GSH;
					end else if (!wa_q[0] && !wb_q[0]) begin
						wa_q <= wa_q >> 1;
						wb_q <= wb_q >> 1;
						k_q <= k_q + pqrho_pkg::K_W'(1);
					end else if (!wa_q[0]) begin
						wa_q <= wa_q >> 1;
					end else if (!wb_q[0]) begin
						wb_q <= wb_q >> 1;
					end else if (!alu_neg) begin
						wa_q <= alu_res[N_W-1:0];
					end else begin
						wa_q <= wb_q;
						wb_q <= wa_q;
					end
				end
				pqrho_pkg::S_GSH: begin
					// restore common powers of two, then judge the step
					if (k_q != '0) begin
						g_q <= g_q << 1;
						k_q <= k_q - pqrho_pkg::K_W'(1);
					end else if (g_q == N_W'(1)) begin
						if (j_pow2) begin
							y_q <= x_q;
						end
						if (j_q == mask_q) begin
							state_q <= pqrho_pkg::S_REND;
						end else begin
							j_q <= j_q + pqrho_pkg::J_W'(1);
							state_q <= pqrho_pkg::S_MSTART;
						end
					end else begin
						state_q <= pqrho_pkg::S_REND;
					end
				end
				pqrho_pkg::S_REND: begin
					if (g_q != N_W'(1) && g_q != n_q) begin
						// proper divisor: cofactor n / g
						wb_q <= n_q;
						wa_q <= '0;
						div_d_q <= g_q;
						cnt_q <= '1;
						kind_q <= pqrho_pkg::DK_QUOT;
						state_q <= pqrho_pkg::S_DIV;
					end else if (r_q < pqrho_pkg::R_W'(pqrho_pkg::MIN_ROUNDS - 1) ||
							steps_q < pqrho_pkg::STEP_W'(pqrho_pkg::MIN_STEPS)) begin
						r_q <= r_q + pqrho_pkg::R_W'(1);
						mask_q <= {mask_q[pqrho_pkg::J_W-2:0], 1'b1};
						state_q <= pqrho_pkg::S_RINIT;
					end else begin
						status_q <= pqrho_pkg::ST_NONE;
						small_q <= '0;
						large_q <= '0;
						small_bytes_q <= '0;
						large_bytes_q <= '0;
						done_q <= 1'b1;
						state_q <= pqrho_pkg::S_IDLE;
					end
				end
				pqrho_pkg::S_FIN: begin
					if (fin_large[N_W-1:pqrho_pkg::F_W] != '0) begin
						// larger factor does not fit the result field
						status_q <= pqrho_pkg::ST_REJECT;
						small_q <= '0;
						large_q <= '0;
						small_bytes_q <= '0;
						large_bytes_q <= '0;
					end else begin
						status_q <= pqrho_pkg::ST_FOUND;
						small_q <= fin_small[pqrho_pkg::F_W-1:0];
						large_q <= fin_large[pqrho_pkg::F_W-1:0];
						small_bytes_q <= pqrho_pkg::byte_len(fin_small[pqrho_pkg::F_W-1:0]);
						large_bytes_q <= pqrho_pkg::byte_len(fin_large[pqrho_pkg::F_W-1:0]);
					end
					done_q <= 1'b1;
					state_q <= pqrho_pkg::S_IDLE;
				end
				default: state_q <= pqrho_pkg::S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != pqrho_pkg::S_IDLE);
	assign done = done_q;
	assign small_factor = small_q;
	assign large_factor = large_q;
	assign small_bytes = small_bytes_q;
	assign large_bytes = large_bytes_q;
	assign status = status_q;

`ifndef SYNTHESIS
	// A result is only ever presented once the sequencer is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == pqrho_pkg::S_IDLE)
		else $error("result strobe outside idle");

	// An accepted request either starts the search or answers at once
	a_start_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done_q))
		else $error("accepted request dropped");

	// Divider is never run against a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pqrho_pkg::S_DIV |-> div_d_q != '0)
		else $error("division by zero");

	// A found pair is ordered and carries byte counts; failures carry zeros
	a_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((status_q == pqrho_pkg::ST_FOUND && small_q <= large_q &&
			small_bytes_q != '0 && large_bytes_q != '0) ||
			(status_q != pqrho_pkg::ST_FOUND && small_q == '0 && large_q == '0)))
		else $error("malformed result");
`endif

endmodule

// ----- verif/tb.sv -----
module tb;
	import pqrho_pkg::*;

	// Expected answer for one composite
	typedef struct packed {
		logic [F_W-1:0]      small_f;
		logic [F_W-1:0]      large_f;
		logic [BYTES_W-1:0]  small_len;
		logic [BYTES_W-1:0]  large_len;
		logic [STATUS_W-1:0] code;
	} factor_result_t;

	// One accepted request: the number sent and what must come back for it
	typedef struct packed {
		logic [N_W-1:0] n;
		factor_result_t res;
	} factor_request_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [N_W-1:0]      composite;
	logic                done;
	logic [F_W-1:0]      small_factor;
	logic [F_W-1:0]      large_factor;
	logic [BYTES_W-1:0]  small_bytes;
	logic [BYTES_W-1:0]  large_bytes;
	logic [STATUS_W-1:0] status;
	logic                cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [N_W-1:0]      cfg_wdata;

	pq_factorization_pollard_rho_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.composite    (composite),
		.done         (done),
		.small_factor (small_factor),
		.large_factor (large_factor),
		.small_bytes  (small_bytes),
		.large_bytes  (large_bytes),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	// Local copy of the two registers, kept in step with every write
	logic [CB_W-1:0] base_const;
	logic [N_W-1:0]  seed_val;

	factor_request_t awaited_factors[$];
	factor_request_t oldest;
	string           bad_fields;
	int unsigned     mismatch_count;
	int unsigned     burst_left;
	longint unsigned cycle_count;
	// Timeout grows with the predicted work of every accepted request
	longint unsigned cycle_budget;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// a + b mod n with a 65-bit sum, both operands already below n
	function automatic logic [N_W-1:0] mod_add(input logic [N_W-1:0] a, input logic [N_W-1:0] b,
			input logic [N_W-1:0] n);
		logic [N_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, n}) begin
			s = s - {1'b0, n};
		end
		return s[N_W-1:0];
	endfunction

	// x*x + c mod n by shift-and-add, as the hardware walks the multiplier bits
	function automatic logic [N_W-1:0] rho_next(input logic [N_W-1:0] x, input logic [N_W-1:0] c,
			input logic [N_W-1:0] n);
		logic [N_W-1:0] acc;
		logic [N_W-1:0] a;
		logic [N_W-1:0] b;
		acc = c;
		a = x;
		b = x;
		while (b != '0) begin
			if (b[0]) begin
				acc = mod_add(acc, a, n);
			end
			a = mod_add(a, a, n);
			b = b >> 1;
		end
		return acc;
	endfunction

	function automatic logic [N_W-1:0] gcd_u64(input logic [N_W-1:0] a, input logic [N_W-1:0] b);
		logic [N_W-1:0] t;
		while (b != '0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic logic [BYTES_W-1:0] bytes_needed(input logic [F_W-1:0] v);
		if (v < 32'd256) begin
			return 3'd1;
		end else if (v < 32'd65536) begin
			return 3'd2;
		end else if (v < 32'd16777216) begin
			return 3'd3;
		end
		return 3'd4;
	endfunction

	// Runs the whole rho search for n under the current registers.
	// Returns 0 if the search would need more than step_cap steps.
	function automatic bit predict_factors(input logic [N_W-1:0] n, input int unsigned step_cap,
			output factor_result_t res, output int unsigned steps);
		int unsigned    r;
		int unsigned    sh;
		logic [N_W-1:0] g;
		logic [N_W-1:0] c;
		logic [N_W-1:0] x;
		logic [N_W-1:0] y;
		logic [N_W-1:0] z;
		logic [N_W-1:0] lim;
		logic [N_W-1:0] j;
		logic [N_W-1:0] p_lo;
		logic [N_W-1:0] p_hi;
		logic [N_W-1:0] t;
		res = '0;
		steps = 0;
		g = '0;
		if (n < 64'd4) begin
			res.code = ST_REJECT;
			return 1'b1;
		end
		for (r = 0; r < MIN_ROUNDS || steps < MIN_STEPS; r++) begin
			// odd rounds shift the polynomial constant by 16
			c = ({48'd0, base_const} + ((r & 1) ? 64'd16 : 64'd0)) % n;
			x = (seed_val + N_W'(r)) % (n - 64'd1) + 64'd1;
			y = x;
			sh = ROUND_SHIFT + r;
			if (sh > 63) begin
				sh = 63;
			end
			lim = 64'd1 << sh;
			for (j = 64'd1; j < lim; j++) begin
				if (steps >= step_cap) begin
					return 1'b0;
				end
				steps++;
				x = rho_next(x, c, n);
				z = (x < y) ? (n - y) + x : x - y;
				g = gcd_u64(z, n);
				if (g != 64'd1) begin
					break;
				end
				// Brent: refresh the saved point at powers of two
				if ((j & (j - 64'd1)) == '0) begin
					y = x;
				end
			end
			if (g > 64'd1 && g < n) begin
				break;
			end
		end
		if (!(g > 64'd1 && g < n)) begin
			res.code = ST_NONE;
			return 1'b1;
		end
		p_lo = g;
		p_hi = n / g;
		if (p_lo > p_hi) begin
			t = p_lo;
			p_lo = p_hi;
			p_hi = t;
		end
		if (p_hi > 64'hFFFF_FFFF) begin
			res.code = ST_REJECT;
			return 1'b1;
		end
		res.small_f = p_lo[F_W-1:0];
		res.large_f = p_hi[F_W-1:0];
		res.small_len = bytes_needed(p_lo[F_W-1:0]);
		res.large_len = bytes_needed(p_hi[F_W-1:0]);
		res.code = ST_FOUND;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Shared tasks
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[cycle %0d] %s", cycle_count, msg);
	endtask

	// Sends one request. Skips it (sent = 0) when the search would run past step_cap,
	// so that no single request can stall the run.
	// Called and left at a falling edge.
	task automatic send_number(input logic [N_W-1:0] n, input int unsigned step_cap,
			output bit sent);
		factor_request_t req;
		int unsigned     nsteps;
		sent = predict_factors(n, step_cap, req.res, nsteps);
		if (!sent) begin
			return;
		end
		req.n = n;
		// bursts of back-to-back requests with idle gaps between them
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			repeat ($urandom_range(0, 12)) begin
				composite = {$urandom, $urandom};
				@(negedge clk);
			end
		end
		burst_left--;
		start = 1'b1;
		composite = n;
		// held until the block takes it; start while busy must be ignored
		do begin
			@(posedge clk);
		end while (busy);
		awaited_factors.push_back(req);
		cycle_budget += 10000 + 2500 * longint'(nsteps);
		@(negedge clk);
		start = 1'b0;
		composite = {$urandom, $urandom};
	endtask

	// Block is idle once the last request has answered
	task automatic wait_idle();
		while (awaited_factors.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [N_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = {$urandom, $urandom};
		if (idx == CFG_CONST_BASE) begin
			base_const = data[CB_W-1:0];
		end else begin
			seed_val = data;
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset values of the registers: constant 17, seed 0
	task automatic test_reset_defaults();
		bit ok;
		send_number(64'd4, 5000, ok);
		send_number(64'd6, 5000, ok);
		send_number(64'd15, 5000, ok);
		// wide composites with small factors: larger factor overflows 32 bits
		send_number(64'h7FFF_FFFF_FFFF_FFFF, 5000, ok);
		send_number(64'hFFFF_FFFF_FFFF_FFFF, 5000, ok);
	endtask

	// Inputs below 4 are rejected; small primes find no factor
	task automatic test_rejects_and_primes();
		bit ok;
		send_number(64'd0, 5000, ok);
		send_number(64'd1, 5000, ok);
		send_number(64'd2, 5000, ok);
		send_number(64'd3, 5000, ok);
		send_number(64'd5, 5000, ok);
		send_number(64'd7, 5000, ok);
		send_number(64'd251, 5000, ok);
	endtask

	// Byte lengths 1..4 and the wide-factor case
	task automatic test_factor_sizes();
		bit ok;
		send_number(64'd12884901873, 5000, ok);  // 3 * 4294967291
		send_number(64'd8589934622, 5000, ok);   // 2 * (2^32 + 15)
		send_number(64'd65535, 5000, ok);
		send_number(64'd4211080463, 5000, ok);   // 251 * 16777213
	endtask

	// Constant zero, constant and seed all ones; upper write bits must not leak
	task automatic test_register_extremes();
		bit ok;
		wait_idle();
		write_reg(CFG_CONST_BASE, 64'hDEAD_BEEF_CAFE_0000);
		send_number(64'd10403, 5000, ok);
		send_number(64'd221, 5000, ok);
		wait_idle();
		write_reg(CFG_CONST_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_START_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_number(64'd10403, 5000, ok);
		send_number(64'd1000001, 5000, ok);
		wait_idle();
		write_reg(CFG_CONST_BASE, 64'h0000_0000_0000_0001);
		write_reg(CFG_START_SEED, 64'd0);
		send_number(64'd221, 5000, ok);
	endtask

	// Mostly p*q with a small p so the search ends quickly and usually finds it;
	// some wide numbers, some tiny ones and some rejects mixed in
	task automatic test_random_phases();
		int unsigned    phase;
		int unsigned    sent_count;
		int unsigned    kind;
		logic [N_W-1:0] p;
		logic [N_W-1:0] q;
		logic [N_W-1:0] n;
		bit             ok;
		for (phase = 0; phase < 4; phase++) begin
			wait_idle();
			write_reg(CFG_CONST_BASE, {$urandom, $urandom});
			write_reg(CFG_START_SEED, {$urandom, $urandom});
			sent_count = 0;
			while (sent_count < 20) begin
				kind = $urandom_range(0, 99);
				p = N_W'($urandom_range(2, 300));
				if (kind < 55) begin
					q = {$urandom, $urandom} >> $urandom_range(32, 62);
					n = p * q;
				end else if (kind < 75) begin
					q = {$urandom, $urandom} >> $urandom_range(0, 8);
					n = p * q;
				end else if (kind < 85) begin
					n = N_W'($urandom_range(4, 600));
				end else if (kind < 95) begin
					n = {$urandom, $urandom} & ~64'd1;
				end else begin
					n = N_W'($urandom_range(0, 3));
				end
				send_number(n, 400, ok);
				if (ok) begin
					sent_count++;
				end
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Result checking: every strobe must match the oldest pending request
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (awaited_factors.size() == 0) begin
				report_mismatch($sformatf("result with no request pending, status %0d", status));
			end else begin
				oldest = awaited_factors.pop_front();
				bad_fields = "";
				if (small_factor !== oldest.res.small_f) begin
					bad_fields = {bad_fields, $sformatf(" small_factor %0d/%0d",
						small_factor, oldest.res.small_f)};
				end
				if (large_factor !== oldest.res.large_f) begin
					bad_fields = {bad_fields, $sformatf(" large_factor %0d/%0d",
						large_factor, oldest.res.large_f)};
				end
				if (small_bytes !== oldest.res.small_len) begin
					bad_fields = {bad_fields, $sformatf(" small_bytes %0d/%0d",
						small_bytes, oldest.res.small_len)};
				end
				if (large_bytes !== oldest.res.large_len) begin
					bad_fields = {bad_fields, $sformatf(" large_bytes %0d/%0d",
						large_bytes, oldest.res.large_len)};
				end
				if (status !== oldest.res.code) begin
					bad_fields = {bad_fields, $sformatf(" status %0d/%0d",
						status, oldest.res.code)};
				end
				if (bad_fields != "") begin
					report_mismatch($sformatf("n=%0d got/expected:%s", oldest.n, bad_fields));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_budget) begin
			$display("timeout at cycle %0d, %0d requests pending", cycle_count,
				awaited_factors.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		composite = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_CONST_BASE;
		cfg_wdata = '0;
		base_const = CONST_BASE_RST;
		seed_val = START_SEED_RST;
		mismatch_count = 0;
		burst_left = 0;
		cycle_count = 0;
		cycle_budget = 200000;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_rejects_and_primes();
		test_factor_sizes();
		test_register_extremes();
		test_random_phases();

		// drain, then watch for stray strobes
		while (awaited_factors.size() != 0) begin
			@(posedge clk);
		end
		repeat (500) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
